>>> src/swmax_pkg.sv
// Shared types and constants of the sliding window maximum block.
package swmax_pkg;

	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(2);

	typedef struct packed {
		logic adv;
		logic restart;
		logic in_win;
	} cell_ctrl_t;

endpackage

>>> src/swmax_cell.sv
// One cell of the candidate chain: a sample of fixed age and its candidate flag.
module swmax_cell
	import swmax_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cell_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
	input  logic                           prev_alive,
	output logic signed [SAMPLE_WIDTH-1:0] value_q,
	output logic                           alive_q
);

	logic beaten;

	assign beaten = prev_value < sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (ctrl.adv) begin
			alive_q <= prev_alive && ctrl.in_win && !ctrl.restart && !beaten;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			value_q <= prev_value;
		end
	end

endmodule

>>> src/swmax_select.sv
// Pick of the oldest live candidate and the result output register.
module swmax_select
	import swmax_pkg::*;
#(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic                           out_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] values [MAX_WINDOW],
	input  logic        [MAX_WINDOW-1:0]   alive,
	output logic                           out_valid,
	output logic signed [SAMPLE_WIDTH-1:0] window_max
);

	logic [MAX_WINDOW-1:0]          alive_rev;
	logic [MAX_WINDOW-1:0]          pick_rev;
	logic [MAX_WINDOW-1:0]          pick;
	logic signed [SAMPLE_WIDTH-1:0] front;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] window_max_q;

	always_comb begin
		for (int k = 0; k < MAX_WINDOW; k++) begin
			alive_rev[k] = alive[MAX_WINDOW-1-k];
		end
		pick_rev = alive_rev & (~alive_rev + MAX_WINDOW'(1));
		for (int k = 0; k < MAX_WINDOW; k++) begin
			pick[k] = pick_rev[MAX_WINDOW-1-k];
		end
		front = '0;
		for (int k = 0; k < MAX_WINDOW; k++) begin
			front = front | (values[k] & {SAMPLE_WIDTH{pick[k]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			window_max_q <= front;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

endmodule

>>> src/sliding_window_max_deque.sv
// Top level of the sliding window maximum: chain of age cells and result stage.
// Path: an accepted sample is registered in the cell chain, and its result then in the result stage register.
// Throughput: one sample per cycle while in_stall is low; the cell chain shifts once per transfer.
// A stalled result holds back the next sample only while a second result waits.
// Reset clears the candidate flags, the sample count and the output valid,
// and sets window_len to 2; candidate values are not reset.
module sliding_window_max_deque
	import swmax_pkg::*;
#(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic        [CFG_W-1:0]        window_len,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           restart,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] window_max
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0]               window_len_q;
	logic [CNT_W-1:0]               seen_q;
	logic [CNT_W-1:0]               seen_next;
	logic [CW-1:0]                  w_eff;
	logic                           pend_s1;
	logic                           accept;
	logic                           can_load;
	logic                           emit;
	logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
	logic        [MAX_WINDOW-1:0]   cell_alive;
	cell_ctrl_t                     cell_ctrl  [MAX_WINDOW];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_len_q <= window_len;
		end
	end

	always_comb begin
		if (window_len_q == '0) begin
			w_eff = CW'(1);
		end else if (CW'(window_len_q) > CW'(MAX_WINDOW)) begin
			w_eff = CW'(MAX_WINDOW);
		end else begin
			w_eff = CW'(window_len_q);
		end
	end

	assign can_load = !out_valid || !out_stall;
	assign in_stall = pend_s1 && !can_load;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (restart) begin
			seen_next = CNT_W'(1);
		end else if (CW'(seen_q) < CW'(MAX_WINDOW)) begin
			seen_next = seen_q + CNT_W'(1);
		end else begin
			seen_next = seen_q;
		end
	end

	assign emit = CW'(seen_next) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (accept) begin
				seen_q <= seen_next;
			end
			if (accept) begin
				pend_s1 <= emit;
			end else if (can_load) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		always_comb begin
			cell_ctrl[k].adv     = accept;
			cell_ctrl[k].restart = (k != 0) && restart;
			cell_ctrl[k].in_win  = CW'(k) < w_eff;
		end

		if (k == 0) begin : g_head
			swmax_cell #(
				.SAMPLE_WIDTH(SAMPLE_WIDTH)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cell_ctrl[k]),
				.sample    (sample),
				.prev_value(sample),
				.prev_alive(1'b1),
				.value_q   (cell_value[k]),
				.alive_q   (cell_alive[k])
			);
		end else begin : g_body
			swmax_cell #(
				.SAMPLE_WIDTH(SAMPLE_WIDTH)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cell_ctrl[k]),
				.sample    (sample),
				.prev_value(cell_value[k-1]),
				.prev_alive(cell_alive[k-1]),
				.value_q   (cell_value[k]),
				.alive_q   (cell_alive[k])
			);
		end
	end

	swmax_select #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (pend_s1 && can_load),
		.out_stall (out_stall),
		.values    (cell_value),
		.alive     (cell_alive),
		.out_valid (out_valid),
		.window_max(window_max)
	);

endmodule

>>> src/swmax_checker.sv
// Port-level checks of the sliding window maximum and their binding.
module swmax_checker
	import swmax_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [SAMPLE_WIDTH-1:0] window_max
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_max))
		else $error("result changed while stalled");

	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a sample transfer two cycles before");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side is free");

	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without a transfer");

endmodule

bind sliding_window_max_deque swmax_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_swmax_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.window_max(window_max)
);
